/* rtl/c8ie_pkg.sv */
// ----------------------------------------------------------------------------
// c8ie_pkg
// shared types and constants of the chip8 instruction executor
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam int          PC_W     = 12;
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } c8ie_cmd_t;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] F_GET_DT = 8'h07;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I  = 8'h1E;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STORE  = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_EXEC,
    ST_FLAG,
    ST_BCD,
    ST_STORE_RD,
    ST_STORE_WR,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_PUT
  } c8ie_state_t;

  typedef struct packed {
    c8ie_state_t step;
    logic        accept;
    logic        load_out;
  } c8ie_dp_cmd_t;

  typedef struct packed {
    logic        clear_done;
    logic        loop_last;
    logic [15:0] opcode;
  } c8ie_dp_stat_t;

endpackage

/* rtl/chip8_instruction_executor_core.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_executor_core
// chip8 core: memory byte load/read and single instruction execution
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid/in_ready, in_cmd, in_address, in_data, in_random_byte
// out      output     out_valid/out_ready, six result fields
// cfg      input      cfg_valid/cfg_ready, cfg_start_address
//
// write, read and nop go from idle straight to the handoff state; execution
// passes fetch hi, fetch lo and exec. alu ops with flag add a vf write, bcd
// writes three digits; fx55/fx65 move one byte per access, read then write.
// after reset a clearing pass zeroes memory, registers and stack, in_ready low.
// a waiting result holds the core in its handoff state until out_ready.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_core #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_next_pc,
  output logic [15:0] out_last_opcode,
  output logic [15:0] out_index_value,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_delay_value,
  output logic [7:0]  out_sound_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_start_address
);

  c8ie_pkg::c8ie_dp_cmd_t  dp_cmd;
  c8ie_pkg::c8ie_dp_stat_t stat;

  assign cfg_ready = 1'b1;

  c8ie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .dp_cmd    (dp_cmd)
  );

  c8ie_dp #(
    .MEM_BYTES   (MEM_BYTES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_address      (in_address),
    .in_data         (in_data),
    .in_random_byte  (in_random_byte),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_start_address),
    .out_next_pc     (out_next_pc),
    .out_last_opcode (out_last_opcode),
    .out_index_value (out_index_value),
    .out_read_data   (out_read_data),
    .out_delay_value (out_delay_value),
    .out_sound_value (out_sound_value)
  );

endmodule

/* rtl/c8ie_ctrl.sv */
// ----------------------------------------------------------------------------
// c8ie_ctrl
// sequencer for clearing, fetch, execute, block transfers and result handoff
// ----------------------------------------------------------------------------
module c8ie_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  c8ie_pkg::c8ie_dp_stat_t stat,
  output c8ie_pkg::c8ie_dp_cmd_t  dp_cmd
);

  c8ie_pkg::c8ie_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  load;
  logic [3:0]            grp, alu_n;
  logic [7:0]            kk;

  assign grp   = stat.opcode[15:12];
  assign alu_n = stat.opcode[3:0];
  assign kk    = stat.opcode[7:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c8ie_pkg::ST_CLEAR: if (stat.clear_done) state_nxt = c8ie_pkg::ST_IDLE;
      c8ie_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (c8ie_pkg::c8ie_cmd_t'(in_cmd) == c8ie_pkg::CMD_EXEC)
            state_nxt = c8ie_pkg::ST_FETCH_HI;
          else
            state_nxt = c8ie_pkg::ST_PUT;
        end
      end
      c8ie_pkg::ST_FETCH_HI: state_nxt = c8ie_pkg::ST_FETCH_LO;
      c8ie_pkg::ST_FETCH_LO: state_nxt = c8ie_pkg::ST_EXEC;
      c8ie_pkg::ST_EXEC: begin
        state_nxt = c8ie_pkg::ST_PUT;
        if (grp == c8ie_pkg::OP_ALU &&
            (alu_n == c8ie_pkg::ALU_ADD || alu_n == c8ie_pkg::ALU_SUB ||
             alu_n == c8ie_pkg::ALU_SHR || alu_n == c8ie_pkg::ALU_SBN ||
             alu_n == c8ie_pkg::ALU_SHL))
          state_nxt = c8ie_pkg::ST_FLAG;
        else if (grp == c8ie_pkg::OP_MISC && kk == c8ie_pkg::F_BCD)
          state_nxt = c8ie_pkg::ST_BCD;
        else if (grp == c8ie_pkg::OP_MISC && kk == c8ie_pkg::F_STORE)
          state_nxt = c8ie_pkg::ST_STORE_RD;
        else if (grp == c8ie_pkg::OP_MISC && kk == c8ie_pkg::F_LOAD)
          state_nxt = c8ie_pkg::ST_LOAD_RD;
      end
      c8ie_pkg::ST_FLAG:     state_nxt = c8ie_pkg::ST_PUT;
      c8ie_pkg::ST_BCD:      if (stat.loop_last) state_nxt = c8ie_pkg::ST_PUT;
      c8ie_pkg::ST_STORE_RD: state_nxt = c8ie_pkg::ST_STORE_WR;
      c8ie_pkg::ST_STORE_WR: begin
        state_nxt = stat.loop_last ? c8ie_pkg::ST_PUT : c8ie_pkg::ST_STORE_RD;
      end
      c8ie_pkg::ST_LOAD_RD:  state_nxt = c8ie_pkg::ST_LOAD_WR;
      c8ie_pkg::ST_LOAD_WR: begin
        state_nxt = stat.loop_last ? c8ie_pkg::ST_PUT : c8ie_pkg::ST_LOAD_RD;
      end
      c8ie_pkg::ST_PUT: if (!out_valid_r || out_ready) state_nxt = c8ie_pkg::ST_IDLE;
      default: state_nxt = c8ie_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == c8ie_pkg::ST_IDLE);
    load            = (state_r == c8ie_pkg::ST_PUT) && (!out_valid_r || out_ready);
    dp_cmd.step     = state_r;
    dp_cmd.accept   = in_ready && in_valid;
    dp_cmd.load_out = load;
    out_valid_nxt   = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c8ie_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/c8ie_dp.sv */
// ----------------------------------------------------------------------------
// c8ie_dp
// memories, architectural registers, alu and result register
// ----------------------------------------------------------------------------
module c8ie_dp #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  c8ie_pkg::c8ie_dp_cmd_t  dp_cmd,
  output c8ie_pkg::c8ie_dp_stat_t stat,
  input  logic [1:0]              in_cmd,
  input  logic [11:0]             in_address,
  input  logic [7:0]              in_data,
  input  logic [7:0]              in_random_byte,
  input  logic                    cfg_we,
  input  logic [11:0]             cfg_data,
  output logic [11:0]             out_next_pc,
  output logic [15:0]             out_last_opcode,
  output logic [15:0]             out_index_value,
  output logic [7:0]              out_read_data,
  output logic [7:0]              out_delay_value,
  output logic [7:0]              out_sound_value
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  regs [16];
  logic [11:0] stack [STACK_DEPTH];

  logic [AW-1:0]  clr_r, raddr, mem_wa, blk_addr;
  logic [7:0]     mem_q, mem_wd, hi_r, vx_q, vy_q, rnd_r;
  logic [11:0]    stk_q, pc_r, pc_nxt, addr_r;
  logic [15:0]    op_r, i_r, i_nxt, fetched;
  logic [7:0]     dt_r, dt_nxt, st_r, st_nxt;
  logic [SPW-1:0] sp_r, sp_nxt, sp_dec, sp_inc, stk_wa;
  logic [3:0]     k_r, ra, rb, reg_wa, x;
  logic [7:0]     reg_wd;
  logic           mem_we, reg_we, stk_we, vread, flag_r, flag_nxt;
  logic [1:0]     cmd_r;
  logic [11:0]    stk_wd;
  logic [7:0]     d_hun, d_ten, d_one, d0_r, d1_r, d2_r;
  logic [6:0]     rem;
  logic [14:0]    prod;
  logic [8:0]     sum;

  assign x        = op_r[11:8];
  assign fetched  = {hi_r, mem_q};
  assign blk_addr = i_r[AW-1:0] + AW'(k_r);
  assign sp_dec   = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign sp_inc   = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;

  // bcd digits
  always_comb begin
    d_hun = (vx_q >= 8'd200) ? 8'd2 : ((vx_q >= 8'd100) ? 8'd1 : 8'd0);
    rem   = 7'(vx_q - 8'(d_hun * 8'd100));
    prod  = 15'(rem) * 15'd205;
    d_ten = {4'd0, prod[14:11]};
    d_one = 8'(rem) - 8'(d_ten * 8'd10);
  end

  // read addresses
  always_comb begin
    case (dp_cmd.step)
      c8ie_pkg::ST_IDLE: begin
        raddr = (c8ie_pkg::c8ie_cmd_t'(in_cmd) == c8ie_pkg::CMD_EXEC) ?
                pc_r[AW-1:0] : in_address[AW-1:0];
      end
      c8ie_pkg::ST_FETCH_HI: raddr = pc_r[AW-1:0] + 1'b1;
      c8ie_pkg::ST_LOAD_RD:  raddr = blk_addr;
      default:               raddr = addr_r[AW-1:0];
    endcase
    vread = (dp_cmd.step == c8ie_pkg::ST_FETCH_LO) ||
            (dp_cmd.step == c8ie_pkg::ST_STORE_RD);
    ra    = (dp_cmd.step == c8ie_pkg::ST_FETCH_LO) ? fetched[11:8] : k_r;
    rb    = (fetched[15:12] == c8ie_pkg::OP_JPV) ? 4'd0 : fetched[7:4];
  end

  // execute and write ports
  always_comb begin
    pc_nxt   = pc_r;
    i_nxt    = i_r;
    dt_nxt   = dt_r;
    st_nxt   = st_r;
    sp_nxt   = sp_r;
    flag_nxt = flag_r;
    reg_we   = 1'b0;
    reg_wa   = x;
    reg_wd   = 8'd0;
    stk_we   = 1'b0;
    stk_wa   = sp_r;
    stk_wd   = pc_r;
    mem_we   = 1'b0;
    mem_wa   = blk_addr;
    mem_wd   = vx_q;
    sum      = {1'b0, vx_q} + {1'b0, vy_q};
    case (dp_cmd.step)
      c8ie_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 8'd0;
        reg_we = 1'b1;
        reg_wa = clr_r[3:0];
        stk_we = (clr_r < AW'(STACK_DEPTH));
        stk_wa = clr_r[SPW-1:0];
        stk_wd = 12'd0;
      end
      c8ie_pkg::ST_IDLE: begin
        mem_we = dp_cmd.accept &&
                 (c8ie_pkg::c8ie_cmd_t'(in_cmd) == c8ie_pkg::CMD_WRITE);
        mem_wa = in_address[AW-1:0];
        mem_wd = in_data;
      end
      c8ie_pkg::ST_FETCH_LO: pc_nxt = pc_r + 12'd2;
      c8ie_pkg::ST_EXEC: begin
        case (op_r[15:12])
          c8ie_pkg::OP_SYS: begin
            if (op_r == c8ie_pkg::OPC_RET) begin
              sp_nxt = sp_dec;
              pc_nxt = stk_q;
            end
          end
          c8ie_pkg::OP_JP: pc_nxt = op_r[11:0];
          c8ie_pkg::OP_CALL: begin
            stk_we = 1'b1;
            sp_nxt = sp_inc;
            pc_nxt = op_r[11:0];
          end
          c8ie_pkg::OP_SE:   if (vx_q == op_r[7:0]) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::OP_SNE:  if (vx_q != op_r[7:0]) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::OP_SER:  if (vx_q == vy_q) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::OP_SNER: if (vx_q != vy_q) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::OP_LD: begin
            reg_we = 1'b1;
            reg_wd = op_r[7:0];
          end
          c8ie_pkg::OP_ADD: begin
            reg_we = 1'b1;
            reg_wd = vx_q + op_r[7:0];
          end
          c8ie_pkg::OP_ALU: begin
            reg_we = 1'b1;
            case (op_r[3:0])
              c8ie_pkg::ALU_MOV: reg_wd = vy_q;
              c8ie_pkg::ALU_OR:  reg_wd = vx_q | vy_q;
              c8ie_pkg::ALU_AND: reg_wd = vx_q & vy_q;
              c8ie_pkg::ALU_XOR: reg_wd = vx_q ^ vy_q;
              c8ie_pkg::ALU_ADD: begin
                reg_wd   = sum[7:0];
                flag_nxt = sum[8];
              end
              c8ie_pkg::ALU_SUB: begin
                reg_wd   = vx_q - vy_q;
                flag_nxt = (vx_q > vy_q);
              end
              c8ie_pkg::ALU_SHR: begin
                reg_wd   = {1'b0, vx_q[7:1]};
                flag_nxt = vx_q[0];
              end
              c8ie_pkg::ALU_SBN: begin
                reg_wd   = vy_q - vx_q;
                flag_nxt = (vy_q > vx_q);
              end
              c8ie_pkg::ALU_SHL: begin
                reg_wd   = {vx_q[6:0], 1'b0};
                flag_nxt = vx_q[7];
              end
              default: reg_we = 1'b0;
            endcase
          end
          c8ie_pkg::OP_LDI: i_nxt = {4'd0, op_r[11:0]};
          c8ie_pkg::OP_JPV: pc_nxt = op_r[11:0] + {4'd0, vy_q};
          c8ie_pkg::OP_RND: begin
            reg_we = 1'b1;
            reg_wd = rnd_r & op_r[7:0];
          end
          c8ie_pkg::OP_MISC: begin
            case (op_r[7:0])
              c8ie_pkg::F_GET_DT: begin
                reg_we = 1'b1;
                reg_wd = dt_r;
              end
              c8ie_pkg::F_SET_DT: dt_nxt = vx_q;
              c8ie_pkg::F_SET_ST: st_nxt = vx_q;
              c8ie_pkg::F_ADD_I:  i_nxt  = i_r + {8'd0, vx_q};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8ie_pkg::ST_FLAG: begin
        reg_we = 1'b1;
        reg_wa = c8ie_pkg::FLAG_REG;
        reg_wd = {7'd0, flag_r};
      end
      c8ie_pkg::ST_BCD: begin
        mem_we = 1'b1;
        case (k_r[1:0])
          2'd0:    mem_wd = d0_r;
          2'd1:    mem_wd = d1_r;
          default: mem_wd = d2_r;
        endcase
      end
      c8ie_pkg::ST_STORE_WR: mem_we = 1'b1;
      c8ie_pkg::ST_LOAD_WR: begin
        reg_we = 1'b1;
        reg_wa = k_r;
        reg_wd = mem_q;
      end
      default: ;
    endcase
    if (cfg_we) pc_nxt = cfg_data;
  end

  always_comb begin
    stat.clear_done = (clr_r == '1);
    stat.opcode     = op_r;
    stat.loop_last  = (dp_cmd.step == c8ie_pkg::ST_BCD) ? (k_r == 4'd2) : (k_r == x);
  end

  // storage arrays
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (reg_we) regs[reg_wa] <= reg_wd;
    if (vread) begin
      vx_q <= regs[ra];
      vy_q <= regs[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack[stk_wa] <= stk_wd;
    stk_q <= stack[sp_dec];
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      pc_r   <= c8ie_pkg::PC_RESET;
      op_r   <= 16'd0;
      i_r    <= 16'd0;
      dt_r   <= 8'd0;
      st_r   <= 8'd0;
      sp_r   <= '0;
      k_r    <= 4'd0;
      flag_r <= 1'b0;
    end else begin
      if (dp_cmd.step == c8ie_pkg::ST_CLEAR && clr_r != '1) clr_r <= clr_r + 1'b1;
      pc_r   <= pc_nxt;
      i_r    <= i_nxt;
      dt_r   <= dt_nxt;
      st_r   <= st_nxt;
      sp_r   <= sp_nxt;
      flag_r <= flag_nxt;
      if (dp_cmd.step == c8ie_pkg::ST_FETCH_LO) op_r <= fetched;
      if (dp_cmd.step == c8ie_pkg::ST_EXEC) k_r <= 4'd0;
      else if (dp_cmd.step == c8ie_pkg::ST_BCD || dp_cmd.step == c8ie_pkg::ST_STORE_WR ||
               dp_cmd.step == c8ie_pkg::ST_LOAD_WR)
        k_r <= k_r + 1'b1;
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      cmd_r  <= in_cmd;
      addr_r <= in_address;
      rnd_r  <= in_random_byte;
    end
    if (dp_cmd.step == c8ie_pkg::ST_FETCH_HI) hi_r <= mem_q;
    if (dp_cmd.step == c8ie_pkg::ST_EXEC) begin
      d0_r <= d_hun;
      d1_r <= d_ten;
      d2_r <= d_one;
    end
    if (dp_cmd.load_out) begin
      out_next_pc     <= pc_r;
      out_last_opcode <= op_r;
      out_index_value <= i_r;
      out_read_data   <= (c8ie_pkg::c8ie_cmd_t'(cmd_r) == c8ie_pkg::CMD_READ) ? mem_q : 8'd0;
      out_delay_value <= dt_r;
      out_sound_value <= st_r;
    end
  end

endmodule
